>>> rtl/hamming_even_parity_codec_unit_assert.svh
// Assertion helpers for the Hamming codec.
`ifndef HAMMING_EVEN_PARITY_CODEC_UNIT_ASSERT_SVH
`define HAMMING_EVEN_PARITY_CODEC_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define HEPC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hepc same-cycle check failed");
`define HEPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hepc next-cycle check failed");
`else
`define HEPC_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define HEPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/hepc_pkg.sv
package hepc_pkg;

  localparam int CFG_W  = 5;
  localparam int GEOM_W = 6;
  localparam int RCNT_W = 3;

  localparam logic [CFG_W-1:0] CFG_RESET = 5'd4;

  typedef enum logic {
    CMD_ENCODE = 1'b0,
    CMD_DECODE = 1'b1
  } cmd_t;

  typedef struct packed {
    logic [GEOM_W-1:0] m;
    logic [RCNT_W-1:0] r;
    logic [GEOM_W-1:0] n;
  } geom_t;

  typedef struct packed {
    logic found;
    logic out_of_range;
  } status_t;

  // smallest r with 2^r >= m + r + 1
  function automatic int parity_count(int m);
    int r;
    r = 7;
    for (int k = 7; k >= 0; k--) begin
      if ((1 << k) >= m + k + 1) r = k;
    end
    return r;
  endfunction

  function automatic geom_t geom_of(logic [CFG_W-1:0] cfg, int max_m);
    int    m;
    int    r;
    geom_t g;
    m = int'(cfg);
    if (m < 1) m = 1;
    if (m > max_m) m = max_m;
    r = parity_count(m);
    g.m = GEOM_W'(m);
    g.r = RCNT_W'(r);
    g.n = GEOM_W'(m + r);
    return g;
  endfunction

  function automatic bit is_pow2(int p);
    return (p & (p - 1)) == 0;
  endfunction

  // code position (1-based) of data bit k (0-based)
  function automatic int data_pos(int k);
    int cnt;
    int pos;
    cnt = 0;
    pos = 0;
    for (int p = 1; p < 128; p++) begin
      if (pos == 0 && !is_pow2(p)) begin
        if (cnt == k) pos = p;
        cnt++;
      end
    end
    return pos;
  endfunction

endpackage

>>> rtl/hamming_even_parity_codec_unit.sv
// Hamming single-error-correcting codec, even parity, data length set by the
// one configuration register (data bit count m, 1..MAX_DATA_BITS; 0 acts as 1,
// larger values saturate; reset value 4). Parity count r is the smallest value
// with 2^r >= m+r+1 and the code word spans positions 1..m+r, bit 0 being
// position 1. cmd 0 encodes in_data_word; cmd 1 checks in_received_word,
// reports the syndrome and flips the named bit, or flags out of range and
// leaves the word as is when the syndrome lies past m+r. One word per cycle
// sustained while out_stall is low; the input register loads at the accepting
// edge, then the XOR trees and correction feed the output register once that
// register can take a word. cfg_ready is always high; m, r and n are worked
// out and registered at the write, which must happen only while no word is in
// flight.
`include "hamming_even_parity_codec_unit_assert.svh"

module hamming_even_parity_codec_unit #(
  parameter int MAX_DATA_BITS = 26,
  localparam int DW = MAX_DATA_BITS,
  localparam int RMAX = hepc_pkg::parity_count(MAX_DATA_BITS),
  localparam int CW = DW + RMAX,
  localparam int SW = RMAX
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [hepc_pkg::CFG_W-1:0]  cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_cmd,
  input  logic [DW-1:0]               in_data_word,
  input  logic [CW-1:0]               in_received_word,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [CW-1:0]               out_code_word,
  output logic [hepc_pkg::RCNT_W-1:0] out_parity_bit_count,
  output logic [SW-1:0]               out_error_position,
  output logic                        out_error_found,
  output logic                        out_position_out_of_range
);
  import hepc_pkg::*;

  geom_t         geom_r;
  logic          s1_valid_r;
  logic          s2_valid_r;
  logic          cmd_r;
  logic [DW-1:0] data_r;
  logic [CW-1:0] rx_r;
  logic          s1_ready;
  logic          s2_ready;
  logic [CW-1:0] code_nxt;
  logic [SW-1:0] pos_nxt;
  status_t       status_nxt;

  assign cfg_ready = 1'b1;
  assign s2_ready  = ~s2_valid_r | ~out_stall;
  assign s1_ready  = ~s1_valid_r | s2_ready;
  assign in_stall  = ~s1_ready;
  assign out_valid = s2_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      geom_r     <= geom_of(CFG_RESET, MAX_DATA_BITS);
    end else begin
      if (s1_ready) s1_valid_r <= in_valid;
      if (s2_ready) s2_valid_r <= s1_valid_r;
      if (cfg_valid && cfg_ready) geom_r <= geom_of(cfg_data, MAX_DATA_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && s1_ready) begin
      cmd_r  <= in_cmd;
      data_r <= in_data_word;
      rx_r   <= in_received_word;
    end
    if (s1_valid_r && s2_ready) begin
      out_code_word             <= code_nxt;
      out_parity_bit_count      <= geom_r.r;
      out_error_position        <= pos_nxt;
      out_error_found           <= status_nxt.found;
      out_position_out_of_range <= status_nxt.out_of_range;
    end
  end

  hepc_core #(
    .DW (DW),
    .CW (CW),
    .SW (SW)
  ) u_core (
    .cmd       (cmd_t'(cmd_r)),
    .data      (data_r),
    .received  (rx_r),
    .geom      (geom_r),
    .code_word (code_nxt),
    .syndrome  (pos_nxt),
    .status    (status_nxt)
  );

  `HEPC_ASSERT_SAME(a_oor_implies_found, clk, rst_n, out_valid && out_position_out_of_range, out_error_found)
  `HEPC_ASSERT_SAME(a_found_matches_pos, clk, rst_n, out_valid, out_error_found == (out_error_position != '0))
  `HEPC_ASSERT_SAME(a_no_bits_past_n, clk, rst_n, out_valid, (out_code_word >> geom_r.n) == '0)
  `HEPC_ASSERT_NEXT(a_full_pipe_holds, clk, rst_n, s1_valid_r && s2_valid_r && out_stall, s1_valid_r && s2_valid_r)
  `HEPC_ASSERT_SAME(a_empty_takes_word, clk, rst_n, !s1_valid_r, !in_stall)

endmodule

>>> rtl/hepc_core.sv
module hepc_core #(
  parameter int DW = 26,
  parameter int CW = 31,
  parameter int SW = 5
) (
  input  hepc_pkg::cmd_t    cmd,
  input  logic [DW-1:0]     data,
  input  logic [CW-1:0]     received,
  input  hepc_pkg::geom_t   geom,
  output logic [CW-1:0]     code_word,
  output logic [SW-1:0]     syndrome,
  output hepc_pkg::status_t status
);
  import hepc_pkg::*;

  function automatic logic [CW-1:0] cover_mask(int i);
    logic [CW-1:0] msk;
    msk = '0;
    for (int p = 1; p <= CW; p++) begin
      msk[p-1] = ((p >> i) & 1) != 0;
    end
    return msk;
  endfunction

  logic [DW-1:0] data_m;
  logic [CW-1:0] placed;
  logic [CW-1:0] enc_word;
  logic [SW-1:0] enc_par;
  logic [CW-1:0] rx_word;
  logic [SW-1:0] synd;
  logic [CW-1:0] fix_mask;
  logic [CW-1:0] dec_word;
  logic          in_range;

  // encode: scatter data bits, then parity over covered positions
  for (genvar k = 0; k < DW; k++) begin : g_data
    localparam int P = data_pos(k);
    assign data_m[k]     = data[k] & (GEOM_W'(k) < geom.m);
    assign placed[P-1]   = data_m[k];
    assign enc_word[P-1] = data_m[k];
  end

  for (genvar i = 0; i < SW; i++) begin : g_par
    localparam logic [CW-1:0] COV = cover_mask(i);
    assign placed[(1 << i) - 1]   = 1'b0;
    assign enc_par[i]             = ^(placed & COV);
    assign enc_word[(1 << i) - 1] = enc_par[i];
    assign synd[i]                = ^(rx_word & COV);
  end

  // decode: drop bits past n, syndrome, single-bit fix
  for (genvar p = 0; p < CW; p++) begin : g_pos
    assign rx_word[p]  = received[p] & (GEOM_W'(p) < geom.n);
    assign fix_mask[p] = (synd == SW'(p + 1)) & in_range;
  end

  assign in_range = GEOM_W'(synd) <= geom.n;
  assign dec_word = rx_word ^ fix_mask;

  always_comb begin
    case (cmd)
      CMD_DECODE: begin
        code_word           = dec_word;
        syndrome            = synd;
        status.found        = |synd;
        status.out_of_range = (|synd) & ~in_range;
      end
      default: begin
        code_word           = enc_word;
        syndrome            = '0;
        status.found        = 1'b0;
        status.out_of_range = 1'b0;
      end
    endcase
  end

endmodule
